### hw/rtl/tmrc_pkg.sv
// ----------------------------------------------------------------------------
// tmrc_pkg
// Shared types and constants for the tile map rectangle collision block.
// ----------------------------------------------------------------------------
package tmrc_pkg;

    // item kind, carried on tuser
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } t_bk_state;

    // configuration register indexes
    localparam logic CFG_COL_COUNT = 1'b0;
    localparam logic CFG_ROW_COUNT = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] COL_COUNT_RST = 8'd80;
    localparam logic [6:0] ROW_COUNT_RST = 7'd40;

    // input tdata layout, lowest bit first
    localparam int S_TDATA_W = 88;
    localparam int ROW_LSB   = 0;
    localparam int ROW_FW    = 6;
    localparam int COL_LSB   = 6;
    localparam int COL_FW    = 7;
    localparam int VAL_LSB   = 13;
    localparam int VAL_FW    = 12;
    localparam int X_LSB     = 25;
    localparam int Y_LSB     = 41;
    localparam int EDGE_FW   = 16;
    localparam int W_LSB     = 57;
    localparam int H_LSB     = 72;
    localparam int SIZE_FW   = 15;
    // write fields (row, col, value) sit together at the bottom
    localparam int WF_W      = 25;

    localparam int M_TDATA_W = 8;

    // dividend width for pixel-to-tile conversion (edge + size, non-negative)
    localparam int DIV_W = 17;
    // width of tile counts and their limits
    localparam int CNT_W = 11;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_st;

endpackage

### hw/rtl/tmrc_ram.sv
// ----------------------------------------------------------------------------
// tmrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmrc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/tmrc_fifo.sv
// ----------------------------------------------------------------------------
// tmrc_fifo
// Short first-word-fall-through command queue between front and back end.
// ----------------------------------------------------------------------------
module tmrc_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data,
    output tmrc_pkg::t_fifo_st o_st
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic [AW-1:0]    n_wp;
    logic [AW-1:0]    n_rp;
    logic [AW:0]      n_cnt;

    always_comb begin
        n_wp  = i_push ? AW'(r_wp + 1'b1) : r_wp;
        n_rp  = i_pop  ? AW'(r_rp + 1'b1) : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = (AW+1)'(r_cnt + 1'b1);
        end else if (!i_push && i_pop) begin
            n_cnt = (AW+1)'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data   = r_mem[r_rp];
    assign o_st.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_st.empty = (r_cnt == '0);

endmodule

### hw/rtl/tmrc_front.sv
// ----------------------------------------------------------------------------
// tmrc_front
// Accepts items, holds the tile counts, turns rectangles into clamped tile
// spans and pushes one command per item into the queue.
// ----------------------------------------------------------------------------
module tmrc_front #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int TILE_SIZE = 16,
    parameter int TILE_BITS = 12,
    parameter int ROW_W     = 6,
    parameter int COL_W     = 7,
    parameter int CMD_W     = 40
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [tmrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                             i_s_axis_tuser,
    output logic                             o_push,
    output logic [CMD_W-1:0]                 o_cmd,
    input  tmrc_pkg::t_fifo_st               i_fifo_st
);

    localparam int DW      = tmrc_pkg::DIV_W;
    localparam int CNW     = tmrc_pkg::CNT_W;
    localparam int RECIP_W = DW + 1;
    localparam int PROD_W  = DW + RECIP_W;
    localparam int QT_W    = DW + 9;
    localparam int SW      = DW + 1;
    localparam int WFW     = tmrc_pkg::WF_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << DW) / TILE_SIZE);
    localparam logic [DW-1:0]      TS_D  = DW'(TILE_SIZE);
    localparam logic [CNW-1:0]     MAXC  = CNW'(MAX_COLS);
    localparam logic [CNW-1:0]     MAXR  = CNW'(MAX_ROWS);

    localparam int ROW_FW_L = tmrc_pkg::ROW_FW;
    localparam int COL_FW_L = tmrc_pkg::COL_FW;
    localparam int VAL_FW_L = tmrc_pkg::VAL_FW;

    // lanes: 0 left, 1 right, 2 top, 3 bottom; axis 0 is x, axis 1 is y
    logic [7:0] r_col_count;
    logic [6:0] r_row_count;

    logic en;

    logic                   r_v1, r_v2, r_v3, r_v4;
    tmrc_pkg::t_op          r_op1, r_op2, r_op3, r_op4;
    logic [WFW-1:0]         r_wf1, r_wf2, r_wf3, r_wf4;
    logic [15:0]            r_edge1 [2];
    logic [14:0]            r_size1 [2];
    logic [DW-1:0]          r_d2 [4];
    logic [DW-1:0]          r_d3 [4];
    logic [DW-1:0]          r_qe3 [4];
    logic [DW-1:0]          r_q4 [4];
    logic [1:0]             r_kill2, r_kill3, r_kill4;

    logic [DW-1:0]          n_d2 [4];
    logic [1:0]             n_kill2;
    logic [SW-1:0]          sum [2];
    logic [SW-1:0]          mag [2];
    logic [PROD_W-1:0]      prod [4];
    logic [DW-1:0]          n_qe3 [4];
    logic [QT_W-1:0]        qt [4];
    logic [DW-1:0]          rem [4];
    logic [DW-1:0]          n_q4 [4];

    logic [CNW-1:0]         lim_c, lim_r, cm1, rm1;
    logic [DW-1:0]          hi_c, hi_r;
    logic                   empty_c, empty_r;
    logic [ROW_FW_L-1:0]    wr_row;
    logic [COL_FW_L-1:0]    wr_col;
    logic [VAL_FW_L-1:0]    wr_val;
    logic                   wr_ok;

    // whole pipeline stalls while the last stage cannot push
    assign en              = !(r_v4 && i_fifo_st.full);
    assign o_s_axis_tready = en;
    assign o_push          = r_v4 && !i_fifo_st.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= tmrc_pkg::COL_COUNT_RST;
            r_row_count <= tmrc_pkg::ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmrc_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                tmrc_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // stage 2: non-negative dividends, far-negative far edge kills the axis
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sum[k]      = {{2{r_edge1[k][15]}}, r_edge1[k]} + {3'b000, r_size1[k]};
            mag[k]      = SW'(~sum[k] + 1'b1);
            n_d2[2*k]   = r_edge1[k][15] ? '0 : DW'(r_edge1[k][14:0]);
            n_d2[2*k+1] = sum[k][SW-1] ? '0 : sum[k][DW-1:0];
            n_kill2[k]  = sum[k][SW-1] && (mag[k] >= SW'(TILE_SIZE));
        end
    end

    // stage 3: quotient estimate by reciprocal, low by at most one
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            prod[k]  = PROD_W'(r_d2[k]) * PROD_W'(RECIP);
            n_qe3[k] = prod[k][DW +: DW];
        end
    end

    // stage 4: correction
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qt[k]   = QT_W'(r_qe3[k]) * QT_W'(TILE_SIZE);
            rem[k]  = r_d3[k] - qt[k][DW-1:0];
            n_q4[k] = (rem[k] >= TS_D) ? DW'(r_qe3[k] + 1'b1) : r_qe3[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (en) begin
            r_op1      <= tmrc_pkg::t_op'(i_s_axis_tuser);
            r_wf1      <= i_s_axis_tdata[WFW-1:0];
            r_edge1[0] <= i_s_axis_tdata[tmrc_pkg::X_LSB +: tmrc_pkg::EDGE_FW];
            r_edge1[1] <= i_s_axis_tdata[tmrc_pkg::Y_LSB +: tmrc_pkg::EDGE_FW];
            r_size1[0] <= i_s_axis_tdata[tmrc_pkg::W_LSB +: tmrc_pkg::SIZE_FW];
            r_size1[1] <= i_s_axis_tdata[tmrc_pkg::H_LSB +: tmrc_pkg::SIZE_FW];
            r_op2      <= r_op1;
            r_wf2      <= r_wf1;
            r_kill2    <= n_kill2;
            r_op3      <= r_op2;
            r_wf3      <= r_wf2;
            r_kill3    <= r_kill2;
            r_op4      <= r_op3;
            r_wf4      <= r_wf3;
            r_kill4    <= r_kill3;
            for (int k = 0; k < 4; k++) begin
                r_d2[k]  <= n_d2[k];
                r_d3[k]  <= r_d2[k];
                r_qe3[k] <= n_qe3[k];
                r_q4[k]  <= n_q4[k];
            end
        end
    end

    // clamp to the counts in use; a zero count leaves the span empty
    always_comb begin
        lim_c   = ({3'b000, r_col_count} > MAXC) ? MAXC : {3'b000, r_col_count};
        lim_r   = ({4'b0000, r_row_count} > MAXR) ? MAXR : {4'b0000, r_row_count};
        cm1     = CNW'(lim_c - 1'b1);
        rm1     = CNW'(lim_r - 1'b1);
        hi_c    = (r_q4[1] > DW'(cm1)) ? DW'(cm1) : r_q4[1];
        hi_r    = (r_q4[3] > DW'(rm1)) ? DW'(rm1) : r_q4[3];
        empty_c = r_kill4[0] || (lim_c == '0) || (r_q4[0] > hi_c);
        empty_r = r_kill4[1] || (lim_r == '0) || (r_q4[2] > hi_r);

        wr_row  = r_wf4[tmrc_pkg::ROW_LSB +: ROW_FW_L];
        wr_col  = r_wf4[tmrc_pkg::COL_LSB +: COL_FW_L];
        wr_val  = r_wf4[tmrc_pkg::VAL_LSB +: VAL_FW_L];
        wr_ok   = (CNW'(wr_row) < MAXR) && (CNW'(wr_col) < MAXC);

        // command: {value, col_b, col_a, row_b, row_a, flag, kind}
        if (r_op4 == tmrc_pkg::OP_WRITE) begin
            o_cmd = {TILE_BITS'(wr_val), COL_W'(0), COL_W'(wr_col), ROW_W'(0),
                     ROW_W'(wr_row), wr_ok, tmrc_pkg::OP_WRITE};
        end else begin
            o_cmd = {TILE_BITS'(0), COL_W'(hi_c), COL_W'(r_q4[0]), ROW_W'(hi_r),
                     ROW_W'(r_q4[2]), empty_c || empty_r, tmrc_pkg::OP_QUERY};
        end
    end

endmodule

### hw/rtl/tmrc_back.sv
// ----------------------------------------------------------------------------
// tmrc_back
// Executes queued commands: tile writes into the map RAM and span scans
// for queries, one tile read per cycle, stopping at the first nonzero tile.
// ----------------------------------------------------------------------------
module tmrc_back #(
    parameter int ROW_W     = 6,
    parameter int COL_W     = 7,
    parameter int TILE_BITS = 12,
    parameter int CMD_W     = 40
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [CMD_W-1:0]         i_cmd,
    input  tmrc_pkg::t_fifo_st       i_fifo_st,
    output logic                     o_pop,
    output logic                     o_ram_we,
    output logic [ROW_W+COL_W-1:0]   o_ram_waddr,
    output logic [TILE_BITS-1:0]     o_ram_wdata,
    output logic                     o_ram_re,
    output logic [ROW_W+COL_W-1:0]   o_ram_raddr,
    input  logic [TILE_BITS-1:0]     i_ram_rdata,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic                     o_hit
);

    localparam int ROW_A_LSB = 2;
    localparam int ROW_B_LSB = ROW_A_LSB + ROW_W;
    localparam int COL_A_LSB = ROW_B_LSB + ROW_W;
    localparam int COL_B_LSB = COL_A_LSB + COL_W;
    localparam int VAL_LSB   = COL_B_LSB + COL_W;

    tmrc_pkg::t_bk_state r_state, n_state;
    logic [ROW_W-1:0]    r_r, n_r, r_top, n_top, r_rb, n_rb;
    logic [COL_W-1:0]    r_c, n_c, r_cb, n_cb;
    logic                r_last, n_last, r_pend, n_pend, r_hit, n_hit;
    logic                r_out_valid, n_out_valid, r_out_hit, n_out_hit;

    tmrc_pkg::t_op       c_kind;
    logic                c_flag;
    logic [ROW_W-1:0]    c_row_a, c_row_b;
    logic [COL_W-1:0]    c_col_a, c_col_b;
    logic                slot_free;

    assign c_kind  = tmrc_pkg::t_op'(i_cmd[0]);
    assign c_flag  = i_cmd[1];
    assign c_row_a = i_cmd[ROW_A_LSB +: ROW_W];
    assign c_row_b = i_cmd[ROW_B_LSB +: ROW_W];
    assign c_col_a = i_cmd[COL_A_LSB +: COL_W];
    assign c_col_b = i_cmd[COL_B_LSB +: COL_W];

    assign o_ram_waddr = {c_row_a, c_col_a};
    assign o_ram_wdata = i_cmd[VAL_LSB +: TILE_BITS];
    assign o_ram_raddr = {r_r, r_c};
    assign slot_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_state     = r_state;
        n_r         = r_r;
        n_top       = r_top;
        n_rb        = r_rb;
        n_c         = r_c;
        n_cb        = r_cb;
        n_last      = r_last;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        o_pop       = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            tmrc_pkg::BK_IDLE: begin
                if (!i_fifo_st.empty) begin
                    if (c_kind == tmrc_pkg::OP_WRITE) begin
                        o_pop    = 1'b1;
                        o_ram_we = c_flag;
                    end else if (c_flag) begin
                        // empty span answers at once
                        if (slot_free) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_hit   = 1'b0;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_r     = c_row_a;
                        n_top   = c_row_a;
                        n_rb    = c_row_b;
                        n_c     = c_col_a;
                        n_cb    = c_col_b;
                        n_last  = 1'b0;
                        n_pend  = 1'b0;
                        n_state = tmrc_pkg::BK_SCAN;
                    end
                end
            end
            tmrc_pkg::BK_SCAN: begin
                o_ram_re = !r_last;
                n_pend   = !r_last;
                if (!r_last) begin
                    if (r_r == r_rb) begin
                        n_r = r_top;
                        if (r_c == r_cb) begin
                            n_last = 1'b1;
                        end else begin
                            n_c = COL_W'(r_c + 1'b1);
                        end
                    end else begin
                        n_r = ROW_W'(r_r + 1'b1);
                    end
                end
                // data of the read issued last cycle
                if (r_pend && (i_ram_rdata != '0)) begin
                    n_hit   = 1'b1;
                    n_state = tmrc_pkg::BK_DONE;
                end else if (r_last) begin
                    n_hit   = 1'b0;
                    n_state = tmrc_pkg::BK_DONE;
                end
            end
            tmrc_pkg::BK_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_state     = tmrc_pkg::BK_IDLE;
                end
            end
            default: n_state = tmrc_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tmrc_pkg::BK_IDLE;
            r_last      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_r       <= n_r;
        r_top     <= n_top;
        r_rb      <= n_rb;
        r_c       <= n_c;
        r_cb      <= n_cb;
        r_hit     <= n_hit;
        r_out_hit <= n_out_hit;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_hit      = r_out_hit;

endmodule

### hw/rtl/tilemap_rect_collision.sv
// ----------------------------------------------------------------------------
// tilemap_rect_collision
// Tile map store with rectangle collision queries.
//
//   channel   dir  handshake                        content
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tile write or rectangle query
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready  hit flag, one per query
//   cfg       in   i_cfg_we                         col_count (0), row_count (1)
//
// Front end takes one item per cycle; four-stage span pipeline, then queue.
// Back end: a tile write is done as it is popped; a query makes one map RAM read
// per tile in its span, stopping early when a nonzero tile is met; an empty
// span answers without a scan.
// Reset is synchronous; the map RAM is not cleared and must be written first.
// Input stalls only while the command queue is full; results wait in an
// output register while the back end moves on to queued writes.
// ----------------------------------------------------------------------------
module tilemap_rect_collision #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int TILE_SIZE = 16,
    parameter int TILE_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tmrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tile_row[5:0], tile_col[12:6], tile_value[24:13], rect_x[40:25],
    // rect_y[56:41], rect_w[71:57], rect_h[86:72], zero[87]
    input  logic [tmrc_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // operation
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // hit[0], zero[7:1]
    output logic [tmrc_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int CMD_W     = 2 + 2 * ROW_W + 2 * COL_W + TILE_BITS;
    localparam int Q_DEPTH   = 4;

    logic                w_push;
    logic                w_pop;
    logic [CMD_W-1:0]    w_cmd_in;
    logic [CMD_W-1:0]    w_cmd_out;
    tmrc_pkg::t_fifo_st  w_fifo_st;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [TILE_BITS-1:0] w_ram_wdata;
    logic                w_ram_re;
    logic [ADDR_W-1:0]   w_ram_raddr;
    logic [TILE_BITS-1:0] w_ram_rdata;
    logic                w_hit;

    tmrc_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .TILE_SIZE (TILE_SIZE),
        .TILE_BITS (TILE_BITS),
        .ROW_W     (ROW_W),
        .COL_W     (COL_W),
        .CMD_W     (CMD_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (w_push),
        .o_cmd           (w_cmd_in),
        .i_fifo_st       (w_fifo_st)
    );

    tmrc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_st    (w_fifo_st)
    );

    tmrc_back #(
        .ROW_W     (ROW_W),
        .COL_W     (COL_W),
        .TILE_BITS (TILE_BITS),
        .CMD_W     (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_fifo_st   (w_fifo_st),
        .o_pop       (w_pop),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_hit       (w_hit)
    );

    tmrc_ram #(
        .WIDTH (TILE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_m_axis_tdata = {(tmrc_pkg::M_TDATA_W-1)'(0), w_hit};

`ifndef SYNTHESIS
    // writes are only done between scans
    a_no_wr_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ram_we && w_ram_re))
        else $error("map write during scan");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo_st.empty)
        else $error("command queue popped while empty");

    // the input side only stalls on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> w_fifo_st.full)
        else $error("input stalled without full queue");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for tilemap_rect_collision. Clears a corner patch of the
// map, runs a table of edge-case writes and rectangle queries, then random
// traffic under a range of column and row counts, with random stalls on both
// streams. Queries are picked so that no never-written tile is scanned before a
// hit. Hit flags are checked against the table or a local model of the map.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TILE_PX     = 16;
    localparam int MAP_ROWS    = 64;
    localparam int MAP_COLS    = 128;
    localparam int HOT_ROWS    = 12;
    localparam int HOT_COLS    = 16;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE      = 100;
    localparam int NPH         = 10;
    localparam int TRIES       = 8;

    typedef struct packed {
        tmrc_pkg::t_op      op;
        logic [5:0]         row;
        logic [6:0]         col;
        logic [11:0]        val;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } t_tile_cmd;

    typedef struct packed {
        t_tile_cmd cmd;
        logic      known;
        logic      hit;
    } t_dir_row;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tmrc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tmrc_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tmrc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tmrc_pkg::M_TDATA_W-1:0]  m_tdata;

    // local copy of the map and the count registers
    logic [11:0] tile_map [MAP_ROWS][MAP_COLS];
    bit          tile_set [MAP_ROWS][MAP_COLS];
    logic [7:0]  col_cnt;
    logic [6:0]  row_cnt;
    logic        hit_q [$];

    int n_err   = 0;
    int n_write = 0;
    int n_query = 0;
    int n_hit   = 0;
    int n_set   = 0;
    bit steady  = 0;
    int rx_hold = 0;

    // count settings per phase; -1 picks a random legal count
    int ph_cols  [NPH] = '{80, 128, 1, 0, 255, 80, 129, -1, 128, 1};
    int ph_rows  [NPH] = '{40, 64, 1, 40, 127, 0, 65, -1, 1, 64};
    int ph_items [NPH] = '{120, 120, 80, 50, 120, 50, 80, 120, 70, 70};

    t_dir_row dir_tab [$];

    tilemap_rect_collision uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // span in tiles truncates toward zero, then clamps to the counts in use
    function automatic void tile_span(input t_tile_cmd c, output int lft, output int rgt,
                                      output int top, output int bot);
        int ncols, nrows, xs, ys;
        ncols = (col_cnt > MAP_COLS) ? MAP_COLS : int'(col_cnt);
        nrows = (row_cnt > MAP_ROWS) ? MAP_ROWS : int'(row_cnt);
        xs  = {{16{c.x[15]}}, c.x};
        ys  = {{16{c.y[15]}}, c.y};
        lft = xs / TILE_PX;
        rgt = (xs + int'(c.w)) / TILE_PX;
        top = ys / TILE_PX;
        bot = (ys + int'(c.h)) / TILE_PX;
        if (lft < 0) lft = 0;
        if (rgt > ncols - 1) rgt = ncols - 1;
        if (top < 0) top = 0;
        if (bot > nrows - 1) bot = nrows - 1;
    endfunction

    function automatic logic rect_hit(input t_tile_cmd c);
        int lft, rgt, top, bot;
        tile_span(c, lft, rgt, top, bot);
        for (int cc = lft; cc <= rgt; cc++)
            for (int rr = top; rr <= bot; rr++)
                if (tile_map[rr][cc] != '0) return 1'b1;
        return 1'b0;
    endfunction

    // scan order of the block: a never-written tile met before any hit is off limits
    function automatic bit reads_unset(input t_tile_cmd c);
        int lft, rgt, top, bot;
        tile_span(c, lft, rgt, top, bot);
        for (int cc = lft; cc <= rgt; cc++) begin
            for (int rr = top; rr <= bot; rr++) begin
                if (!tile_set[rr][cc]) return 1'b1;
                if (tile_map[rr][cc] != '0) return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_dir_row tile_wr(input int row, input int col, input int val);
        t_dir_row d;
        d         = '0;
        d.cmd.op  = tmrc_pkg::OP_WRITE;
        d.cmd.row = 6'(row);
        d.cmd.col = 7'(col);
        d.cmd.val = 12'(val);
        return d;
    endfunction

    function automatic t_dir_row rect_q(input int x, input int y, input int w, input int h,
                                        input int known, input int hit);
        t_dir_row d;
        d        = '0;
        d.cmd.op = tmrc_pkg::OP_QUERY;
        d.cmd.x  = 16'(x);
        d.cmd.y  = 16'(y);
        d.cmd.w  = 15'(w);
        d.cmd.h  = 15'(h);
        d.known  = 1'(known);
        d.hit    = 1'(hit);
        return d;
    endfunction

    // pixel edge: mostly near the busy corner or inside the map, sometimes anywhere
    function automatic logic [15:0] pick_edge(input int span, input int hot);
        int k;
        k = $urandom_range(99);
        if (k < 12) return 16'($urandom);
        if (k < 60) return 16'($urandom_range(hot * TILE_PX + 16) - 32);
        return 16'($urandom_range(span * TILE_PX + 64) - 48);
    endfunction

    function automatic t_tile_cmd rand_cmd();
        t_tile_cmd c;
        int ncols, nrows, hcols, hrows, k;
        bit ok;
        ncols = (col_cnt > MAP_COLS) ? MAP_COLS : int'(col_cnt);
        nrows = (row_cnt > MAP_ROWS) ? MAP_ROWS : int'(row_cnt);
        hcols = (ncols < HOT_COLS) ? ncols : HOT_COLS;
        hrows = (nrows < HOT_ROWS) ? nrows : HOT_ROWS;
        c.row = 6'($urandom);
        c.col = 7'($urandom);
        c.val = 12'($urandom);
        c.x   = 16'($urandom);
        c.y   = 16'($urandom);
        c.w   = 15'($urandom);
        c.h   = 15'($urandom);
        if ($urandom_range(99) < 45) begin
            c.op = tmrc_pkg::OP_WRITE;
            k = $urandom_range(99);
            if (k < 55 && hcols > 0 && hrows > 0) begin
                c.row = 6'($urandom_range(hrows - 1));
                c.col = 7'($urandom_range(hcols - 1));
            end else if (k < 80 && ncols > 0 && nrows > 0) begin
                c.row = 6'($urandom_range(nrows - 1));
                c.col = 7'($urandom_range(ncols - 1));
            end
            k = $urandom_range(99);
            if (k < 40)
                c.val = '0;
            else if (k < 45)
                c.val = '1;
        end else begin
            c.op = tmrc_pkg::OP_QUERY;
            ok = 1'b0;
            for (int t = 0; t < TRIES && !ok; t++) begin
                c.x = pick_edge(ncols, hcols);
                c.y = pick_edge(nrows, hrows);
                k = $urandom_range(99);
                // large boxes scan many tiles, so keep them rare
                if (k < 90) begin
                    c.w = 15'($urandom_range(47));
                    c.h = 15'($urandom_range(47));
                end else if (k < 97) begin
                    c.w = 15'($urandom_range(511));
                    c.h = 15'($urandom_range(511));
                end else begin
                    c.w = 15'($urandom);
                    c.h = 15'($urandom);
                end
                ok = !reads_unset(c);
            end
            // fall back to a box inside the cleared corner
            if (!ok) begin
                c.x = 16'($urandom_range(191));
                c.y = 16'($urandom_range(127));
                c.w = 15'($urandom_range(63));
                c.h = 15'($urandom_range(63));
            end
        end
        return c;
    endfunction

    // called and returns at a falling edge
    task automatic put_item(input t_tile_cmd c, input logic known, input logic hit);
        logic [tmrc_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[tmrc_pkg::ROW_LSB +: tmrc_pkg::ROW_FW] = c.row;
        d[tmrc_pkg::COL_LSB +: tmrc_pkg::COL_FW] = c.col;
        d[tmrc_pkg::VAL_LSB +: tmrc_pkg::VAL_FW] = c.val;
        d[tmrc_pkg::X_LSB +: tmrc_pkg::EDGE_FW]  = c.x;
        d[tmrc_pkg::Y_LSB +: tmrc_pkg::EDGE_FW]  = c.y;
        d[tmrc_pkg::W_LSB +: tmrc_pkg::SIZE_FW]  = c.w;
        d[tmrc_pkg::H_LSB +: tmrc_pkg::SIZE_FW]  = c.h;
        if (!steady && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= c.op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (c.op == tmrc_pkg::OP_WRITE) begin
            tile_map[c.row][c.col] = c.val;
            tile_set[c.row][c.col] = 1'b1;
            n_write++;
        end else begin
            hit_q.push_back(known ? hit : rect_hit(c));
            n_query++;
        end
        @(negedge clk);
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (hit_q.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // writes land behind the last result, hence the settle time before a change
    task automatic set_counts(input logic [7:0] cols, input logic [6:0] rows);
        drain_results(SETTLE);
        cfg_we    <= 1'b1;
        cfg_index <= tmrc_pkg::CFG_COL_COUNT;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_index <= tmrc_pkg::CFG_ROW_COUNT;
        cfg_data  <= {1'b0, rows};
        @(negedge clk);
        cfg_we  <= 1'b0;
        col_cnt = cols;
        row_cnt = rows;
        n_set++;
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 6);
            end
        end
    end

    always @(posedge clk) begin : check_results
        logic want;
        if (rst_n && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result: expected none, actual hit=%0b",
                         $time, m_tdata[0]);
            end else begin
                want = hit_q.pop_front();
                if (m_tdata[0] !== want) begin
                    n_err++;
                    $display("%0t: hit mismatch: expected %0b, actual %0b",
                             $time, want, m_tdata[0]);
                end else if (want) begin
                    n_hit++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding", cycles, hit_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_tile_cmd c;
        int ncol, nrow;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = tmrc_pkg::CFG_COL_COUNT;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = tmrc_pkg::OP_WRITE;
        col_cnt   = tmrc_pkg::COL_COUNT_RST;
        row_cnt   = tmrc_pkg::ROW_COUNT_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // map RAM powers up undefined: zero the busy corner before any query
        for (int r = 0; r < HOT_ROWS; r++) begin
            for (int cc = 0; cc < HOT_COLS; cc++) begin
                c     = '0;
                c.op  = tmrc_pkg::OP_WRITE;
                c.row = 6'(r);
                c.col = 7'(cc);
                put_item(c, 1'b0, 1'b0);
            end
        end

        // reset counts 80 x 40, corner clear
        dir_tab = '{
            rect_q(0, 0, 255, 191, 1, 0),
            tile_wr(0, 0, 4095),
            rect_q(0, 0, 0, 0, 1, 1),
            rect_q(-32768, -32768, 0, 0, 1, 0),
            rect_q(-15, -15, 0, 0, 1, 1),        // truncation toward zero gives tile 0
            rect_q(-16, 0, 15, 0, 1, 1),
            rect_q(-17, 0, 0, 0, 1, 0),          // right edge lands on tile -1: empty
            rect_q(0, -17, 0, 0, 1, 0),
            tile_wr(39, 79, 1),
            rect_q(32767, 32767, 32767, 32767, 1, 0),
            rect_q(1264, 624, 0, 0, 1, 1),
            rect_q(240, 176, 15, 15, 1, 0),
            rect_q(1280, 624, 0, 0, 1, 0),       // first column past col_count
            rect_q(1264, 624, 32767, 32767, 1, 1),  // far edges clamp to the last tile
            tile_wr(63, 127, 2),
            rect_q(2032, 1008, 0, 0, 1, 0),
            tile_wr(0, 0, 0),
            rect_q(0, 0, 15, 15, 1, 0),
            tile_wr(5, 10, 2048),
            rect_q(160, 80, 0, 0, 1, 1),
            rect_q(144, 64, 15, 15, 1, 0),
            rect_q(144, 64, 16, 16, 1, 1),
            tile_wr(5, 10, 0),
            tile_wr(0, 0, 7),
            rect_q(0, 0, 32767, 32767, 1, 1),    // first tile hits, scan stops there
            rect_q(100, 50, 100, 100, 0, 0)
        };
        foreach (dir_tab[i])
            put_item(dir_tab[i].cmd, dir_tab[i].known, dir_tab[i].hit);

        for (int p = 0; p < NPH; p++) begin
            ncol = (ph_cols[p] < 0) ? $urandom_range(1, 128) : ph_cols[p];
            nrow = (ph_rows[p] < 0) ? $urandom_range(1, 64) : ph_rows[p];
            set_counts(8'(ncol), 7'(nrow));
            steady = (p == 1);
            // long output stall: the command queue fills and the input backs up
            if (p == 0)
                rx_hold = 500;
            for (int i = 0; i < ph_items[p]; i++) begin
                if (p == 4 && i == ph_items[p] / 2)
                    drain_results(0);
                put_item(rand_cmd(), 1'b0, 1'b0);
            end
        end
        steady = 0;
        drain_results(SETTLE);

        $display("Ran %0d tile writes and %0d queries (%0d hits) over %0d count settings",
                 n_write, n_query, n_hit, n_set);
        $display("incl. zero, saturating and single-tile counts; %0d mismatches", n_err);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
